// ===== hw/rtl/ncm_pkg.sv =====
package ncm_pkg;

   // Field widths fixed by the item formats.
   localparam int OLD_ID_W = 31;
   localparam int NEW_ID_W = 16;
   localparam int NEXT_ID_W = NEW_ID_W + 1;

   // Only the low ID_BITS bits of an old id take part in the mapping.
   localparam int ID_BITS = 31;
   localparam logic [OLD_ID_W-1:0] KEY_MASK = OLD_ID_W'((64'd1 << ID_BITS) - 64'd1);

   // Hash table geometry. The slot index is the low bits of the hash product,
   // so the table holds a power-of-two number of slots.
   localparam int TABLE_ENTRIES = 65536;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

   localparam logic [31:0] HASH_MULT = 32'h9E3779B1;
   localparam logic [NEXT_ID_W-1:0] MAX_NEW_ID = NEXT_ID_W'(65535);

   // Mode codes of an input transaction.
   localparam logic MODE_SOURCE = 1'b0;
   localparam logic MODE_TARGET = 1'b1;

   typedef struct packed {
      logic                mode;
      logic [OLD_ID_W-1:0] old_id;
   } req_type;

   typedef struct packed {
      logic [NEW_ID_W-1:0] new_id;
      logic                newly_assigned;
      logic                table_full;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [OLD_ID_W-1:0] key;
      logic [NEW_ID_W-1:0] value;
   } slot_type;

   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic [IDX_W-1:0] addr;
      slot_type         wdata;
   } mem_req_type;

endpackage

// ===== hw/rtl/ncm_hash.sv =====
module ncm_hash (
   input  logic [ncm_pkg::OLD_ID_W-1:0] key,
   output logic [ncm_pkg::IDX_W-1:0]    slot_idx
);

   logic [31:0] product;

   // Multiplicative hash; the home slot is the product modulo the table size.
   assign product  = {1'b0, key} * ncm_pkg::HASH_MULT;
   assign slot_idx = product[ncm_pkg::IDX_W-1:0];

endmodule

// ===== hw/rtl/ncm_table.sv =====
module ncm_table (
   input  logic                  clock,
   input  ncm_pkg::mem_req_type  mem_req,
   output ncm_pkg::slot_type     rd_data
);

   ncm_pkg::slot_type slots [ncm_pkg::TABLE_ENTRIES];
   ncm_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slots[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= slots[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/node_id_compaction_map.sv =====
// Channel   Direction  Payload                                   Handshake
// req_      in         mode, old_id (ncm_pkg::req_type)          req_valid / req_ready
// rsp_      out        new_id, newly_assigned, table_full        rsp_valid / rsp_ready
//
// A transaction reads its home slot when it is accepted and checks it in ST_CHECK, then
// reads one further slot for each step of linear probing, up to all TABLE_ENTRIES slots; the
// single port of the slot memory sets this, one slot read per cycle.
// After reset a clearing pass writes every one of the TABLE_ENTRIES (65536) slots once, with
// req_ready low. A stalled result waits in the output register; the next request is
// still taken, and only its final step waits for the output register to free up.
module node_id_compaction_map (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ncm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ncm_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK
   } state_type;

   state_type                         state_ff, state_in;
   logic [ncm_pkg::IDX_W-1:0]         clr_cnt_ff, clr_cnt_in;
   logic                              mode_ff, mode_in;
   logic [ncm_pkg::OLD_ID_W-1:0]      key_ff, key_in;
   logic [ncm_pkg::IDX_W-1:0]         pos_ff, pos_in;
   logic [ncm_pkg::IDX_W-1:0]         cnt_ff, cnt_in;
   logic [ncm_pkg::NEXT_ID_W-1:0]     next_free_ff, next_free_in;
   logic [ncm_pkg::OLD_ID_W-1:0]      prev_src_ff, prev_src_in;
   logic [ncm_pkg::NEW_ID_W-1:0]      prev_id_ff, prev_id_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ncm_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic [ncm_pkg::OLD_ID_W-1:0]      req_key;
   logic [ncm_pkg::IDX_W-1:0]         home_idx;
   ncm_pkg::mem_req_type              mem_req;
   ncm_pkg::slot_type                 entry;

   logic                              key_zero;
   logic                              src_repeat;
   logic                              ids_out;
   logic                              hit;
   logic                              empty;
   logic                              probe_done;
   logic                              out_free;
   logic                              commit;
   logic                              take_id;
   logic                              do_insert;
   logic                              upd_prev;
   ncm_pkg::rsp_type                  result;

   assign req_key = req_data.old_id & ncm_pkg::KEY_MASK;

   ncm_hash u_hash (
      .key      (req_key),
      .slot_idx (home_idx)
   );

   ncm_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (entry)
   );

   // Conditions that settle a transaction without the table, and the probe outcome.
   assign key_zero   = (key_ff == '0);
   assign src_repeat = (mode_ff == ncm_pkg::MODE_SOURCE) && (key_ff == prev_src_ff);
   assign ids_out    = (next_free_ff > ncm_pkg::MAX_NEW_ID);
   assign hit        = entry.valid && (entry.key == key_ff);
   assign empty      = !entry.valid;

   always_comb begin
      if (mode_ff == ncm_pkg::MODE_SOURCE) begin
         probe_done = src_repeat || ids_out || key_zero || hit || empty ||
                      (cnt_ff == ncm_pkg::LAST_SLOT);
      end else begin
         probe_done = key_zero || hit || empty || (cnt_ff == ncm_pkg::LAST_SLOT);
      end
   end

   // Result of a finished probe. A source id that is not a repeat gets a fresh id
   // unless ids or slots run out, and is inserted only if the table lacks it; a target
   // id takes the stored value or a fresh, inserted id, or reports table_full.
   always_comb begin
      take_id   = 1'b0;
      do_insert = 1'b0;
      upd_prev  = 1'b0;
      result    = '0;
      if (mode_ff == ncm_pkg::MODE_SOURCE) begin
         if (src_repeat) begin
            result.new_id = prev_id_ff;
         end else if (ids_out) begin
            result.table_full = 1'b1;
         end else if (key_zero || hit) begin
            take_id  = 1'b1;
            upd_prev = 1'b1;
         end else if (empty) begin
            take_id   = 1'b1;
            do_insert = 1'b1;
            upd_prev  = 1'b1;
         end else begin
            result.table_full = 1'b1;
         end
      end else begin
         if (key_zero) begin
            result.new_id = '0;
         end else if (hit) begin
            result.new_id = entry.value;
         end else if (empty && !ids_out) begin
            take_id   = 1'b1;
            do_insert = 1'b1;
         end else begin
            result.table_full = 1'b1;
         end
      end
      if (take_id) begin
         result.new_id         = next_free_ff[ncm_pkg::NEW_ID_W-1:0];
         result.newly_assigned = 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == ST_CHECK) && probe_done && out_free;

   // Slot memory port: clearing writes, the home-slot read on accept, the next
   // probe read on a collision and the insert write on commit never overlap.
   always_comb begin
      mem_req = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en = 1'b1;
            mem_req.addr  = clr_cnt_ff;
         end
         ST_IDLE: begin
            mem_req.rd_en = req_valid;
            mem_req.addr  = home_idx;
         end
         ST_CHECK: begin
            if (!probe_done) begin
               mem_req.rd_en = 1'b1;
               mem_req.addr  = pos_ff + 1'b1;
            end else if (commit && do_insert) begin
               mem_req.wr_en       = 1'b1;
               mem_req.addr        = pos_ff;
               mem_req.wdata.valid = 1'b1;
               mem_req.wdata.key   = key_ff;
               mem_req.wdata.value = next_free_ff[ncm_pkg::NEW_ID_W-1:0];
            end
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      next_free_in = next_free_ff;
      prev_src_in  = prev_src_ff;
      prev_id_in   = prev_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ncm_pkg::LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_data.mode;
               key_in   = req_key;
               pos_in   = home_idx;
               cnt_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!probe_done) begin
               pos_in = pos_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = ST_IDLE;
               if (take_id) begin
                  next_free_in = next_free_ff + 1'b1;
               end
               if (upd_prev) begin
                  prev_src_in = key_ff;
                  prev_id_in  = next_free_ff[ncm_pkg::NEW_ID_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         next_free_ff <= ncm_pkg::NEXT_ID_W'(1);
         prev_src_ff  <= '0;
         prev_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         next_free_ff <= next_free_in;
         prev_src_ff  <= prev_src_in;
         prev_id_ff   <= prev_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // The memory port is single ported: a read and a write never share a cycle.
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("slot memory read and write in the same cycle");

   // No request is taken while the clearing pass runs.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request accepted during clearing pass");

   // Ids are handed out in order and never taken back.
   a_next_free_grows: assert property (@(posedge clock) disable iff (reset)
      commit && take_id |=> next_free_ff == $past(next_free_ff) + 1'b1)
      else $error("fresh id not consumed");

   // A full answer carries id zero and no fresh assignment.
   a_full_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |->
         (rsp_data.new_id == '0) && !rsp_data.newly_assigned)
      else $error("table_full with nonzero id or fresh flag");
`endif

endmodule

// ===== bench/tb_node_id_compaction_map.sv =====
module tb_node_id_compaction_map;
   import ncm_pkg::*;

   // The run is far shorter than this; only a hung block gets here.
   localparam int CYCLE_LIMIT = 5_000_000;
   // Cycles of quiet after the last result. A stray extra result would show up here.
   localparam int SETTLE_CYCLES = 64;
   // Printed mismatch lines are capped so that a broken block cannot flood the log.
   localparam int REPORT_CAP = 200;
   localparam int RANDOM_JOBS = 1500;
   // A short run of alternating source transactions that each take a fresh id.
   localparam int FRESH_JOBS = 40;
   localparam int TAIL_JOBS = 300;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   node_id_compaction_map dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // One transaction waiting to be driven. A job marked drain_first is held back
   // until every result already owed has come out of the block. A calm job is
   // driven with no random idle burst before it.
   typedef struct {
      req_type item;
      bit      drain_first;
      bit      calm;
   } remap_job_type;

   typedef enum logic [1:0] {
      SLOT_HIT,
      SLOT_EMPTY,
      SLOT_NONE
   } probe_result_type;

   remap_job_type       remap_jobs [$];
   rsp_type             expected_ids [$];
   logic [OLD_ID_W-1:0] seen_keys [$];
   int                  jobs_queued = 0;

   // Our own copy of the hash table and the id counters. The table starts
   // cleared, just as the block's clearing pass leaves it.
   bit                  map_used [TABLE_ENTRIES];
   logic [OLD_ID_W-1:0] map_key [TABLE_ENTRIES];
   logic [NEW_ID_W-1:0] map_id [TABLE_ENTRIES];
   logic [NEXT_ID_W-1:0] ids_handed_next = NEXT_ID_W'(1);
   logic [OLD_ID_W-1:0] last_source_key = '0;
   logic [NEW_ID_W-1:0] last_source_new_id = '0;

   // Handshake bookkeeping shared by the driver, the monitor and the stall logic.
   logic req_taken = 1'b0;
   logic calm_phase = 1'b0;
   int   gap_left = 0;
   int   stall_left = 0;
   int   errors = 0;
   int   checked_count = 0;
   int   fresh_count = 0;
   int   full_count = 0;
   int   cycle_count = 0;

   // Linear probe from the multiplicative hash home slot. It reports a hit with
   // the slot of the key, or a miss with the first free slot on the way, or that
   // no slot is free at all.
   function automatic probe_result_type lookup_slot(input logic [OLD_ID_W-1:0] key,
                                                    output int unsigned slot);
      logic [31:0] product;
      int unsigned pos;
      product = {1'b0, key} * HASH_MULT;
      pos = product % 32'(TABLE_ENTRIES);
      slot = 0;
      for (int n = 0; n < TABLE_ENTRIES; n++) begin
         if (!map_used[pos]) begin
            slot = pos;
            return SLOT_EMPTY;
         end
         if (map_key[pos] == key) begin
            slot = pos;
            return SLOT_HIT;
         end
         pos = (pos + 1) % TABLE_ENTRIES;
      end
      return SLOT_NONE;
   endfunction

   // Works out the result of one accepted transaction and advances our state.
   function automatic rsp_type predict_mapping(input req_type item);
      logic [OLD_ID_W-1:0] key;
      rsp_type             res;
      probe_result_type    outcome;
      int unsigned         slot;
      key = item.old_id & KEY_MASK;
      res = '0;
      slot = 0;
      if (item.mode == MODE_SOURCE) begin
         if (key == last_source_key) begin
            // Same source as just before: reuse its id, nothing else moves.
            res.new_id = last_source_new_id;
         end else if (ids_handed_next > MAX_NEW_ID) begin
            res.table_full = 1'b1;
         end else begin
            // Old id zero is implicitly present and never stored.
            if (key == '0) begin
               outcome = SLOT_HIT;
            end else begin
               outcome = lookup_slot(key, slot);
            end
            if (outcome == SLOT_NONE) begin
               res.table_full = 1'b1;
            end else begin
               res.new_id = ids_handed_next[NEW_ID_W-1:0];
               // A key seen earlier keeps its first mapping in the table.
               if (outcome == SLOT_EMPTY) begin
                  map_used[slot] = 1'b1;
                  map_key[slot] = key;
                  map_id[slot] = res.new_id;
               end
               ids_handed_next = ids_handed_next + 1'b1;
               res.newly_assigned = 1'b1;
               last_source_key = key;
               last_source_new_id = res.new_id;
            end
         end
      end else if (key != '0) begin
         outcome = lookup_slot(key, slot);
         if (outcome == SLOT_HIT) begin
            res.new_id = map_id[slot];
         end else if (outcome == SLOT_NONE || ids_handed_next > MAX_NEW_ID) begin
            res.table_full = 1'b1;
         end else begin
            res.new_id = ids_handed_next[NEW_ID_W-1:0];
            map_used[slot] = 1'b1;
            map_key[slot] = key;
            map_id[slot] = res.new_id;
            ids_handed_next = ids_handed_next + 1'b1;
            res.newly_assigned = 1'b1;
         end
      end
      return res;
   endfunction

   task automatic add_job(input logic mode, input logic [OLD_ID_W-1:0] key,
                          input bit drain_first, input bit calm);
      remap_job_type job;
      job.item.mode = mode;
      job.item.old_id = key;
      job.drain_first = drain_first;
      job.calm = calm;
      remap_jobs.insert(remap_jobs.size(), job);
      jobs_queued++;
   endtask

   // Key choice for the random stream: half the time ids already in play, so that
   // lookups hit, plus brand new ids, small ids, zero, and ids that share the
   // home slot of a known id so that probe chains grow.
   function automatic logic [OLD_ID_W-1:0] pick_key();
      logic [OLD_ID_W-1:0] key;
      logic [OLD_ID_W-1:0] known;
      known = (seen_keys.size() == 0) ? OLD_ID_W'(1)
                                      : seen_keys[$urandom_range(0, seen_keys.size() - 1)];
      case ($urandom_range(0, 9))
         0:       key = '0;
         1:       key = OLD_ID_W'($urandom_range(1, 63));
         2, 3:    key = OLD_ID_W'($urandom);
         4:       key = known + (OLD_ID_W'($urandom_range(1, 7)) << 16);
         default: key = known;
      endcase
      if (key != '0) begin
         seen_keys.insert(seen_keys.size(), key);
      end
      return key;
   endfunction

   // Driver. A new transaction is put on the bus only when the bus is free or
   // the one on it was taken at the last rising edge; otherwise valid and the
   // payload hold still. Random idle bursts fall between transactions
   // outside calm stretches.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (remap_jobs.size() == 0) begin
            req_valid <= 1'b0;
         end else if (remap_jobs[0].drain_first && expected_ids.size() != 0) begin
            req_valid <= 1'b0;
         end else if (!remap_jobs[0].calm && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            gap_left <= $urandom_range(0, 3);
         end else begin
            req_valid <= 1'b1;
            req_data <= remap_jobs[0].item;
            calm_phase <= remap_jobs[0].calm;
            void'(remap_jobs.pop_front());
         end
      end
   end

   // Receiver side stalls, in bursts like the sender's idles.
   always @(negedge clock) begin
      if (reset || calm_phase) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor. Results are checked before a request accepted at the same edge is
   // predicted, since that request cannot have produced a result yet.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_ids.size() == 0) begin
               errors++;
               if (errors <= REPORT_CAP) begin
                  $display("%0t: result with none outstanding: new_id %0d fresh %0b full %0b",
                           $time, rsp_data.new_id, rsp_data.newly_assigned,
                           rsp_data.table_full);
               end
            end else begin
               want = expected_ids.pop_front();
               checked_count++;
               if (rsp_data.new_id !== want.new_id) begin
                  errors++;
                  if (errors <= REPORT_CAP) begin
                     $display("%0t: new_id mismatch: expected %0d, actual %0d",
                              $time, want.new_id, rsp_data.new_id);
                  end
               end
               if (rsp_data.newly_assigned !== want.newly_assigned) begin
                  errors++;
                  if (errors <= REPORT_CAP) begin
                     $display("%0t: newly_assigned mismatch: expected %0b, actual %0b",
                              $time, want.newly_assigned, rsp_data.newly_assigned);
                  end
               end
               if (rsp_data.table_full !== want.table_full) begin
                  errors++;
                  if (errors <= REPORT_CAP) begin
                     $display("%0t: table_full mismatch: expected %0b, actual %0b",
                              $time, want.table_full, rsp_data.table_full);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            want = predict_mapping(req_data);
            if (want.newly_assigned) begin
               fresh_count++;
            end
            if (want.table_full) begin
               full_count++;
            end
            expected_ids.insert(expected_ids.size(), want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_ids.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [OLD_ID_W-1:0] wrap_key;
      logic [OLD_ID_W-1:0] src_key;
      logic [31:0]         product;
      int                  known_count;
      bit                  calm;

      // An id whose home slot is the last one, so that its neighbors wrap to slot 0.
      wrap_key = '0;
      for (int k = 1; k < TABLE_ENTRIES; k++) begin
         product = 32'(k) * HASH_MULT;
         if (product[IDX_W-1:0] == LAST_SLOT) begin
            wrap_key = OLD_ID_W'(k);
         end
      end

      // Directed part. Zero as source and target, a source repeated right after
      // itself, a source id coming back later (fresh id, table keeps the old one),
      // the largest id, ids sharing a home slot, and a probe chain that wraps.
      add_job(MODE_SOURCE, '0, 0, 0);
      add_job(MODE_TARGET, '0, 0, 0);
      add_job(MODE_SOURCE, OLD_ID_W'(5), 0, 0);
      add_job(MODE_SOURCE, OLD_ID_W'(5), 0, 0);
      add_job(MODE_TARGET, OLD_ID_W'(5), 0, 0);
      add_job(MODE_TARGET, KEY_MASK, 0, 0);
      add_job(MODE_SOURCE, KEY_MASK, 0, 0);
      add_job(MODE_TARGET, KEY_MASK, 0, 0);
      add_job(MODE_SOURCE, OLD_ID_W'(5), 0, 0);
      add_job(MODE_TARGET, OLD_ID_W'(5), 0, 0);
      add_job(MODE_SOURCE, '0, 0, 0);
      add_job(MODE_TARGET, '0, 0, 0);
      add_job(MODE_TARGET, OLD_ID_W'(5) + (OLD_ID_W'(1) << 16), 0, 0);
      add_job(MODE_TARGET, OLD_ID_W'(5) + (OLD_ID_W'(2) << 16), 0, 0);
      add_job(MODE_TARGET, OLD_ID_W'(5) + (OLD_ID_W'(2) << 16), 0, 0);
      add_job(MODE_TARGET, wrap_key, 0, 0);
      add_job(MODE_TARGET, wrap_key + (OLD_ID_W'(1) << 16), 0, 0);
      add_job(MODE_TARGET, wrap_key + (OLD_ID_W'(2) << 16), 0, 0);
      add_job(MODE_TARGET, wrap_key + (OLD_ID_W'(2) << 16), 0, 0);
      add_job(MODE_SOURCE, OLD_ID_W'(31'h2AAA_AAAA), 0, 0);
      add_job(MODE_TARGET, OLD_ID_W'(31'h5555_5555), 0, 0);
      add_job(MODE_SOURCE, OLD_ID_W'(31'h4000_0000), 0, 0);
      add_job(MODE_TARGET, OLD_ID_W'(31'h2AAA_AAAA), 0, 0);
      seen_keys = {OLD_ID_W'(5), KEY_MASK, OLD_ID_W'(5) + (OLD_ID_W'(1) << 16),
                   OLD_ID_W'(5) + (OLD_ID_W'(2) << 16), wrap_key,
                   wrap_key + (OLD_ID_W'(1) << 16), wrap_key + (OLD_ID_W'(2) << 16),
                   OLD_ID_W'(31'h2AAA_AAAA), OLD_ID_W'(31'h5555_5555),
                   OLD_ID_W'(31'h4000_0000)};

      // Random part, shaped like a sorted edge list: a source id repeated once
      // per edge, each followed by its target. Some groups are plain noise, some
      // stretches run without idles, and now and then the sender waits for the
      // block to empty before going on.
      known_count = jobs_queued + RANDOM_JOBS;
      while (jobs_queued < known_count) begin
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               add_job(logic'($urandom_range(0, 1)), pick_key(),
                       $urandom_range(0, 39) == 0, calm);
            end
         end else begin
            src_key = pick_key();
            add_job(MODE_SOURCE, src_key,
                    jobs_queued == known_count - RANDOM_JOBS || $urandom_range(0, 39) == 0,
                    calm);
            add_job(MODE_TARGET, pick_key(), 0, calm);
            repeat ($urandom_range(0, 4)) begin
               add_job(MODE_SOURCE, src_key, 0, calm);
               add_job(MODE_TARGET, pick_key(), 0, calm);
            end
         end
      end

      // Alternating old id zero with ids already in play hands out a fresh id
      // every transaction without growing the table. The first of these waits
      // for the block to drain.
      known_count = seen_keys.size();
      for (int n = 0; n < FRESH_JOBS; n++) begin
         if (n % 2 == 0) begin
            add_job(MODE_SOURCE, '0, n == 0, 1);
         end else begin
            add_job(MODE_SOURCE, seen_keys[$urandom_range(0, known_count - 1)], 0, 1);
         end
      end

      // A final stretch of mixed lookups and new ids with no idles and no stalls.
      for (int n = 0; n < TAIL_JOBS; n++) begin
         add_job(logic'($urandom_range(0, 1)), pick_key(), 0, 1);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (remap_jobs.size() != 0 || req_valid || expected_ids.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d results over %0d transactions: %0d fresh ids, %0d full answers.",
               checked_count, jobs_queued, fresh_count, full_count);
      $display("Covered source repeats, id zero, shared and wrapping probe chains, stalls.");
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
